// File: design/mactp_pkg.sv
// Shared types, constants and character decode for the MAC address text parser.
`default_nettype none

package mactp_pkg;

  // Text layout
  localparam int unsigned MacW      = 48;
  localparam int unsigned CountW    = 5;
  localparam logic [CountW-1:0] TEXT_LEN  = 5'd17;
  localparam logic [CountW-1:0] COUNT_SAT = 5'd18;

  // Characters
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;

  // Group bit: bit 0 of the first octet
  localparam int unsigned GroupBit = 40;

  // One character waiting in the input register
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  // One finished result
  typedef struct packed {
    logic [MacW-1:0] mac;
    logic            ok;
  } mac_result_t;

  // Decoded hex digit: valid flag and nibble
  typedef struct packed {
    logic       hit;
    logic [3:0] nib;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    logic [7:0] t;
    d.hit = 1'b0;
    d.nib = 4'd0;
    t     = 8'd0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      t     = c - CHAR_0;
      d.hit = 1'b1;
    end else if (c >= CHAR_LA && c <= CHAR_LF) begin
      t     = c - CHAR_LA + 8'd10;
      d.hit = 1'b1;
    end else if (c >= CHAR_UA && c <= CHAR_UF) begin
      t     = c - CHAR_UA + 8'd10;
      d.hit = 1'b1;
    end
    d.nib = t[3:0];
    return d;
  endfunction

endpackage

`default_nettype wire

// File: design/mactp_in_stage.sv
// Input register: holds one character item until the parser takes it.
`default_nettype none

module mactp_in_stage
  import mactp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire char_item_t in_item,
  input  wire logic       out_free,
  output logic            step_en,
  output char_item_t      item
);

  logic       valid_r;
  char_item_t item_r;

  // An item moves on unless it closes a text and the result slot is busy
  assign step_en  = valid_r && (!item_r.last || out_free);
  assign in_ready = !valid_r || step_en;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

// File: design/mactp_parse.sv
// Parser state and per-character decode; builds the result on the last character.
`default_nettype none

module mactp_parse
  import mactp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire char_item_t item,
  output logic            res_valid,
  output mac_result_t     res
);

  logic [CountW-1:0] count_r, count_nxt;
  logic [7:0]        sep_r, sep_nxt;
  logic [MacW-1:0]   shift_r, shift_nxt;
  logic              bad_r, bad_nxt;
  hex_digit_t        dig;
  logic              mac_ok;

  assign dig = hex_decode(item.ch);

  // Next state for one character
  always_comb begin
    count_nxt = count_r;
    sep_nxt   = sep_r;
    shift_nxt = shift_r;
    bad_nxt   = bad_r;
    if (count_r >= TEXT_LEN) begin
      bad_nxt = 1'b1;
    end else if (count_r inside {5'd2, 5'd5, 5'd8, 5'd11, 5'd14}) begin
      if (count_r == 5'd2) begin
        sep_nxt = item.ch;
        if (item.ch != CHAR_COLON && item.ch != CHAR_DASH) bad_nxt = 1'b1;
      end else if (item.ch != sep_r) begin
        bad_nxt = 1'b1;
      end
    end else if (!dig.hit) begin
      bad_nxt = 1'b1;
    end else begin
      shift_nxt = {shift_r[MacW-5:0], dig.nib};
    end
    if (count_r < COUNT_SAT) count_nxt = count_r + 5'd1;
  end

  // Result checks: well formed, nonzero, not broadcast, not group
  always_comb begin
    mac_ok = !bad_nxt && (count_nxt == TEXT_LEN) &&
             (shift_nxt != '0) && (shift_nxt != '1) && !shift_nxt[GroupBit];
    res_valid = step_en && item.last;
    res.ok    = mac_ok;
    res.mac   = mac_ok ? shift_nxt : '0;
  end

  // State registers; cleared after each result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sep_r   <= '0;
      shift_r <= '0;
      bad_r   <= 1'b0;
    end else if (step_en) begin
      if (item.last) begin
        count_r <= '0;
        sep_r   <= '0;
        shift_r <= '0;
        bad_r   <= 1'b0;
      end else begin
        count_r <= count_nxt;
        sep_r   <= sep_nxt;
        shift_r <= shift_nxt;
        bad_r   <= bad_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/mactp_out_stage.sv
// Result register: holds one result until the downstream side takes it.
`default_nettype none

module mactp_out_stage
  import mactp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        res_valid,
  input  wire mac_result_t res,
  output logic             out_free,
  output logic             out_valid,
  input  wire logic        out_ready,
  output mac_result_t      out_res
);

  logic        valid_r;
  mac_result_t res_r;

  assign out_free  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_free) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

// File: design/mac_address_text_parser.sv
// Top level of the MAC address text parser.
`default_nettype none

// Takes a MAC address as text, one ASCII character per item (tlast on the
// final character), in the form xx:xx:xx:xx:xx:xx or xx-xx-xx-xx-xx-xx with
// hex digits of either case. On the item that carries tlast one result is
// sent: the 48-bit address (first octet in bits 47:40) and an ok flag in
// tuser. The flag is clear, and the address reads zero, when the text is not
// exactly 17 characters, has a bad digit or separator, or the address is all
// zeros, broadcast or a group address. Characters without tlast give no
// result. The block takes one character per cycle: an input register feeds a
// combinational decode and state update, and a result register decouples the
// output side, so a new character is accepted every cycle unless a finished
// text meets a result register that is still full and not being taken.
module mac_address_text_parser
  import mactp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_in
  input  wire logic        in_tlast,   // last_char
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [47:0] mac_value
  output logic             out_tuser   // [0] addr_ok
);

  char_item_t  in_item;
  char_item_t  item;
  logic        step_en;
  logic        out_free;
  logic        res_valid;
  mac_result_t res;
  mac_result_t out_res;

  assign in_item.ch   = in_tdata;
  assign in_item.last = in_tlast;

  mactp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .out_free (out_free),
    .step_en  (step_en),
    .item     (item)
  );

  mactp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  mactp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = out_res.mac;
  assign out_tuser = out_res.ok;

endmodule

`default_nettype wire

// File: design/mactp_checker.sv
// Port-level checks for the MAC address text parser, bound to the top level.
`default_nettype none

module mactp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic        out_tuser
);

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // A rejected text reports a zero address
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 48'd0)
    else $error("rejected result carries an address");

  // An accepted address is unicast, nonzero and not broadcast
  a_ok_unicast: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      !out_tdata[40] && out_tdata != 48'd0 && out_tdata != 48'hFFFF_FFFF_FFFF)
    else $error("accepted address is zero, broadcast or group");

  // A fresh result comes from an accepted item that closed its text, through the input and result registers
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast, 2))
    else $error("result without a closing item");

endmodule

bind mac_address_text_parser mactp_checker u_mactp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// File: tb/sv/mac_address_text_parser_test.sv
// Self-checking testbench for the MAC address text parser: directed texts, then random texts.
`timescale 1ns / 1ps

module mac_address_text_parser_test
  import mactp_pkg::*;
();

  typedef logic [7:0] char_q_t[$];

  // One directed text: optional raw lead character, text, and whether it must be rejected
  typedef struct {
    logic [7:0] lead;
    bit         has_lead;
    string      text;
    bit         reject;
  } text_row_t;

  // Categories of random text
  typedef enum int {
    TXT_GOOD    = 0,
    TXT_CORRUPT = 1,
    TXT_LENGTH  = 2,
    TXT_SEP_MIX = 3,
    TXT_NOISE   = 4
  } text_kind_t;

  localparam int unsigned RandItems = 450;
  localparam int unsigned DrainWait = 20;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tuser;

  // Parser state as tracked by the testbench
  logic [CountW-1:0] seen_count;
  logic [7:0]        seen_sep;
  logic [MacW-1:0]   seen_digits;
  bit                seen_bad;

  mac_result_t pending_macs[$];
  int unsigned err_count;
  bit          in_burst;
  bit          out_burst;

  mac_address_text_parser uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 100 MHz clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hex value of a character; bit 4 set when it is not a hex digit
  function automatic logic [4:0] nibble_of(input logic [7:0] ch);
    if (ch >= CHAR_0 && ch <= CHAR_9) return {1'b0, 4'(ch - CHAR_0)};
    if (ch >= CHAR_LA && ch <= CHAR_LF) return {1'b0, 4'(ch - CHAR_LA + 8'd10)};
    if (ch >= CHAR_UA && ch <= CHAR_UF) return {1'b0, 4'(ch - CHAR_UA + 8'd10)};
    return 5'h10;
  endfunction

  // Advance the tracked state by one character; returns 1 when a result is due
  function automatic bit parse_char(input logic [7:0] ch, input bit last,
                                    output mac_result_t res);
    logic [CountW-1:0] pos;
    logic [4:0]        nib;
    pos = seen_count;
    res = '0;
    if (pos >= TEXT_LEN) begin
      seen_bad = 1'b1;
    end else if (pos % 3 == 2) begin
      if (pos == 2) begin
        seen_sep = ch;
        if (ch != CHAR_COLON && ch != CHAR_DASH) seen_bad = 1'b1;
      end else if (ch != seen_sep) begin
        seen_bad = 1'b1;
      end
    end else begin
      nib = nibble_of(ch);
      if (nib[4]) seen_bad = 1'b1;
      else seen_digits = {seen_digits[MacW-5:0], nib[3:0]};
    end
    if (seen_count < COUNT_SAT) seen_count = seen_count + 1'b1;
    if (!last) return 1'b0;
    // zero, broadcast and group addresses are refused
    res.ok = !seen_bad && seen_count == TEXT_LEN && seen_digits != '0 &&
             seen_digits != '1 && !seen_digits[GroupBit];
    res.mac = res.ok ? seen_digits : '0;
    seen_count  = '0;
    seen_sep    = '0;
    seen_digits = '0;
    seen_bad    = 1'b0;
    return 1'b1;
  endfunction

  // Send one character; queue the expected result when it ends a text
  task automatic send_char(input logic [7:0] ch, input bit last, input bit reject);
    int unsigned gap;
    mac_result_t res;
    bit          took;
    gap = in_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= last;
    // sample ready mid-cycle, so it is the value seen at the next edge
    do begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end while (!took);
    if (parse_char(ch, last, res)) begin
      if (reject) res = '0;
      pending_macs.push_back(res);
    end
  endtask

  task automatic send_text(input char_q_t txt, input bit reject);
    for (int i = 0; i < txt.size(); i++) send_char(txt[i], i == txt.size() - 1, reject);
  endtask

  // Hold off the sender until every queued result has come out
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_macs.size() != 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    text_row_t   dir_rows[$];
    char_q_t     txt;
    text_kind_t  kind;
    logic [47:0] mac;
    logic [7:0]  sep;
    logic [3:0]  nib;
    int unsigned rand_items;
    int unsigned r;
    int unsigned len;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    seen_count  = '0;
    seen_sep    = '0;
    seen_digits = '0;
    seen_bad    = 1'b0;
    err_count   = 0;
    in_burst    = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // good texts, address extremes, and malformed texts
    dir_rows.push_back('{8'h00, 1'b0, "02:00:00:00:00:01", 1'b0});
    dir_rows.push_back('{8'h00, 1'b0, "0A-bC-dE-Ff-09-aB", 1'b0});
    dir_rows.push_back('{8'h00, 1'b0, "FE:dc:BA:98:76:54", 1'b0});
    dir_rows.push_back('{8'h00, 1'b0, "00:00:00:00:00:00", 1'b1});
    dir_rows.push_back('{8'h00, 1'b0, "ff:ff:ff:ff:ff:ff", 1'b1});
    dir_rows.push_back('{8'h00, 1'b0, "01-00-5e-00-00-01", 1'b1});
    dir_rows.push_back('{8'h00, 1'b0, "02:00:00:00:00:01:23:45", 1'b1});
    dir_rows.push_back('{8'h00, 1'b0, "02:00", 1'b1});
    dir_rows.push_back('{8'h00, 1'b0, "02.00.00.00.00.01", 1'b1});
    dir_rows.push_back('{8'h00, 1'b0, "02:00-00:00:00:01", 1'b1});
    dir_rows.push_back('{8'h00, 1'b0, "0g:00:00:00:00:01", 1'b1});
    dir_rows.push_back('{8'h00, 1'b0, "02:/0:@0:`0:G0:01", 1'b1});
    dir_rows.push_back('{8'h00, 1'b1, "", 1'b1});
    dir_rows.push_back('{8'hFF, 1'b1, "", 1'b1});

    foreach (dir_rows[n]) begin
      txt.delete();
      if (dir_rows[n].has_lead) txt.push_back(dir_rows[n].lead);
      for (int i = 0; i < dir_rows[n].text.len(); i++) txt.push_back(dir_rows[n].text[i]);
      send_text(txt, dir_rows[n].reject);
    end
    drain_results();

    // random texts, mostly well formed
    rand_items = 0;
    while (rand_items < RandItems) begin
      in_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) drain_results();
      r    = $urandom_range(0, 9);
      kind = (r < 6) ? TXT_GOOD : text_kind_t'(r - 5);
      sep  = $urandom_range(0, 1) ? CHAR_COLON : CHAR_DASH;
      mac  = 48'({$urandom, $urandom});
      if ($urandom_range(0, 3) != 0) mac[GroupBit] = 1'b0;
      if ($urandom_range(0, 15) == 0) mac = '0;
      else if ($urandom_range(0, 15) == 0) mac = '1;
      txt.delete();
      for (int k = 0; k < 12; k++) begin
        nib = mac[47 - 4 * k -: 4];
        if (k > 0 && k % 2 == 0) txt.push_back(sep);
        if (nib < 10) txt.push_back(CHAR_0 + 8'(nib));
        else txt.push_back(($urandom_range(0, 1) ? CHAR_UA : CHAR_LA) + 8'(nib) - 8'd10);
      end
      case (kind)
        TXT_CORRUPT: txt[$urandom_range(0, 16)] = 8'($urandom_range(0, 255));
        TXT_LENGTH: begin
          if ($urandom_range(0, 1)) begin
            len = $urandom_range(1, 16);
            while (txt.size() > len) void'(txt.pop_back());
          end else begin
            repeat ($urandom_range(1, 8)) txt.push_back($urandom_range(0, 1) ? sep : CHAR_UA);
          end
        end
        TXT_SEP_MIX:
          txt[3 * $urandom_range(2, 5) - 1] = (sep == CHAR_COLON) ? CHAR_DASH : CHAR_COLON;
        TXT_NOISE: begin
          txt.delete();
          repeat ($urandom_range(1, 25)) txt.push_back(8'($urandom_range(0, 255)));
        end
        default: ;
      endcase
      send_text(txt, 1'b0);
      rand_items += txt.size();
    end

    // wait for the last results, then let the pipeline settle
    drain_results();
    repeat (DrainWait) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side: random stalls, compare with the oldest expectation
  initial begin
    int unsigned stall;
    mac_result_t want;
    bit          got;
    logic [47:0] got_mac;
    logic        got_ok;
    out_tready = 1'b0;
    out_burst  = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
      stall = out_burst ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      // capture the result mid-cycle, as it stands at the accepting edge
      do begin
        @(negedge clk);
        got     = out_tvalid;
        got_mac = out_tdata;
        got_ok  = out_tuser;
        @(posedge clk);
      end while (!got);
      if (pending_macs.size() == 0) begin
        $error("unexpected result: mac_value %h addr_ok %b", got_mac, got_ok);
        err_count++;
      end else begin
        want = pending_macs.pop_front();
        if (got_mac !== want.mac) begin
          $error("mac_value: expected %h, got %h", want.mac, got_mac);
          err_count++;
        end
        if (got_ok !== want.ok) begin
          $error("addr_ok: expected %b, got %b", want.ok, got_ok);
          err_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
